### src/encoder_step_accumulator_top_defines.svh
// Assertion macros for the encoder step accumulator RTL.
// Depends on nothing; expects aclk and aresetn in the scope of each use.
`ifndef ENCODER_STEP_ACCUMULATOR_TOP_DEFINES_SVH
`define ENCODER_STEP_ACCUMULATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ESA_ASSERT_IMPL(label, ante, cons) \
label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
    else $error("esa: assertion failed");

// Next-cycle implication, disabled during reset.
`define ESA_ASSERT_NEXT(label, ante, cons) \
label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
    else $error("esa: assertion failed");

`endif

### src/esa_pkg.sv
// Shared types and constants of the encoder step accumulator.
// Depends on nothing.
package esa_pkg;

    localparam int NUM_ENCODERS = 4;
    localparam int IDX_W        = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

    localparam int IN_IDX_W = 8;    // encoder_index field
    localparam int CNT_W    = 16;   // raw counter and accumulator
    localparam int REM_W    = 9;    // signed sub-step remainder
    localparam int CPS_W    = 8;    // counts_per_step
    localparam int SUM_W    = 17;   // remainder + delta, also divider width
    localparam int ACC_X_W  = CNT_W + 2;
    localparam int DIV_CNT_W = $clog2(SUM_W);
    localparam int ENTRY_W  = CNT_W + REM_W + CNT_W;

    // stream field positions
    localparam int IDX_LSB   = 0;
    localparam int RAW_LSB   = IDX_LSB + IN_IDX_W;
    localparam int VALID_BIT = RAW_LSB + CNT_W;
    localparam int S_DATA_W  = 32;

    localparam logic [CPS_W-1:0]    CPS_RESET = 8'd2;
    localparam logic [IN_IDX_W-1:0] IDX_LIMIT = IN_IDX_W'(NUM_ENCODERS);
    localparam logic [CNT_W-1:0]    STEP_ACC_MAX = 16'h7FFF;
    localparam logic [CNT_W-1:0]    STEP_ACC_MIN = 16'h8000;

    localparam logic OP_POLL = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] prev;
        logic [REM_W-1:0] rem;
        logic [CNT_W-1:0] acc;
    } entry_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
        logic [CPS_W-1:0] remainder;
    } div_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_START,
        ST_DIV,
        ST_UPDATE,
        ST_RESP
    } state_t;

endpackage

### src/encoder_step_accumulator_top.sv
// Encoder step accumulator: top level with control sequencer and state table.
// Depends on esa_pkg, esa_ram, esa_div and encoder_step_accumulator_top_defines.svh.
//
// Usage:
//   Input channel s_*: one transaction per poll or read item. s_tuser selects
//   the operation (poll or read-and-clear). A poll carries a raw counter
//   sample; the encoder's remainder and step accumulator are updated in a
//   per-encoder table held in one RAM, and no result is produced.
//   Output channel m_*: one transaction per read item, carrying the
//   saturated step count since the previous read (zero for a bad index).
//   Config: cfg_wen/cfg_wdata write counts_per_step (0 acts as 1); write
//   only while the block is idle.
//   Throughput: one item at a time. A poll steps through table read, sum,
//   divider start, the 17-bit bit-serial divider up to its done flag, and
//   write back. A read goes through table read and the response state (a
//   bad index skips the table read) before m_tvalid rises, and s_tready is
//   back in that same cycle.
//   Polls that are flagged invalid or hit a bad index are dropped on acceptance; the block stays idle.
//   Reset: table entries read as zero through per-entry valid flops;
//   counts_per_step returns to 2. No clearing pass.
//   Stall: the result sits in an output register while polls go on; a read
//   then waits in the response state, s_tready low, until the register is free.
`include "encoder_step_accumulator_top_defines.svh"

module encoder_step_accumulator_top
    import esa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // configuration: counts_per_step
    input  logic                cfg_wen,
    input  logic [CPS_W-1:0]    cfg_wdata,
    // input transactions
    input  logic                s_tvalid,
    output logic                s_tready,
    // [7:0] encoder_index, [23:8] raw_count, [24] count_valid, [31:25] zero
    input  logic [S_DATA_W-1:0] s_tdata,
    // [0] operation
    input  logic                s_tuser,
    // result transactions
    output logic                m_tvalid,
    input  logic                m_tready,
    // [15:0] step count
    output logic [CNT_W-1:0]    m_tdata
);

    state_t state_reg, state_next;

    logic [CPS_W-1:0]    cps_reg;
    logic                op_reg;
    logic [IN_IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0]    raw_reg;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [NUM_ENCODERS-1:0] vld_reg;
    logic                m_tvalid_reg;
    logic [CNT_W-1:0]    m_tdata_reg;

    logic                accept;
    logic [IN_IDX_W-1:0] s_idx;
    logic                s_in_range;
    logic                in_range;
    logic [IDX_W-1:0]    s_addr, addr;
    logic [CPS_W-1:0]    divisor;
    logic                out_free;
    logic                out_load;
    logic [CNT_W-1:0]    out_data;
    logic                latch_in;
    logic                load_sum;

    // table port
    logic             mem_we, mem_re;
    entry_t           mem_wdata;
    logic [ENTRY_W-1:0] mem_rdata;
    entry_t           entry;

    // divider
    logic             div_start;
    logic [SUM_W-1:0] div_dividend;
    div_res_t         div_res;

    // update arithmetic
    logic [CNT_W-1:0]   delta;
    logic [ACC_X_W-1:0] acc_ext, q_ext, acc_sum;
    logic [CNT_W-1:0]   acc_sat;
    logic [REM_W-1:0]   rem_s;
    logic               sum_neg;

    assign accept     = s_tvalid && s_tready;
    assign s_idx      = s_tdata[IDX_LSB +: IN_IDX_W];
    assign s_in_range = (s_idx < IDX_LIMIT);
    assign s_addr     = s_idx[IDX_W-1:0];
    assign in_range   = (idx_reg < IDX_LIMIT);
    assign addr       = idx_reg[IDX_W-1:0];
    assign divisor    = (cps_reg == '0) ? CPS_W'(1) : cps_reg;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign sum_neg    = sum_reg[SUM_W-1];

    // never-written entries read as zero
    assign entry = vld_reg[addr] ? entry_t'(mem_rdata) : '0;

    esa_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(NUM_ENCODERS)
    ) u_table (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (addr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (s_addr),
        .rdata (mem_rdata)
    );

    esa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (divisor),
        .res      (div_res)
    );

    // wrapped delta plus sign-extended remainder
    always_comb begin
        delta    = raw_reg - entry.prev;
        sum_next = {{(SUM_W - REM_W){entry.rem[REM_W-1]}}, entry.rem}
                 + {{(SUM_W - CNT_W){delta[CNT_W-1]}}, delta};
    end

    assign div_dividend = sum_neg ? (SUM_W'(0) - sum_reg) : sum_reg;

    // quotient takes the sign of the sum; saturate to 16 bits
    always_comb begin
        acc_ext = {{(ACC_X_W - CNT_W){entry.acc[CNT_W-1]}}, entry.acc};
        q_ext   = {{(ACC_X_W - SUM_W){1'b0}}, div_res.quotient};
        acc_sum = sum_neg ? (acc_ext - q_ext) : (acc_ext + q_ext);
        if (acc_sum[ACC_X_W-1:CNT_W-1] == '0 || acc_sum[ACC_X_W-1:CNT_W-1] == '1) begin
            acc_sat = acc_sum[CNT_W-1:0];
        end else if (acc_sum[ACC_X_W-1]) begin
            acc_sat = STEP_ACC_MIN;
        end else begin
            acc_sat = STEP_ACC_MAX;
        end
        rem_s = sum_neg ? (REM_W'(0) - {1'b0, div_res.remainder})
                        : {1'b0, div_res.remainder};
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        latch_in   = 1'b0;
        load_sum   = 1'b0;
        mem_re     = 1'b0;
        mem_we     = 1'b0;
        mem_wdata  = entry;
        div_start  = 1'b0;
        out_load   = 1'b0;
        out_data   = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    latch_in = 1'b1;
                    if (s_tuser == OP_READ) begin
                        mem_re     = s_in_range;
                        state_next = s_in_range ? ST_FETCH : ST_RESP;
                    end else if (s_in_range && s_tdata[VALID_BIT]) begin
                        mem_re     = 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                if (op_reg == OP_READ) begin
                    state_next = ST_RESP;
                end else begin
                    load_sum   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_res.done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                mem_we         = 1'b1;
                mem_wdata.prev = raw_reg;
                mem_wdata.rem  = rem_s;
                mem_wdata.acc  = acc_sat;
                state_next     = ST_IDLE;
            end
            ST_RESP: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_data      = in_range ? entry.acc : '0;
                    mem_we        = in_range;
                    mem_wdata.acc = '0;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cps_reg      <= CPS_RESET;
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wen) begin
                cps_reg <= cfg_wdata;
            end
            if (mem_we) begin
                vld_reg[addr] <= 1'b1;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (latch_in) begin
            op_reg  <= s_tuser;
            idx_reg <= s_idx;
            raw_reg <= s_tdata[RAW_LSB +: CNT_W];
        end
        if (load_sum) begin
            sum_reg <= sum_next;
        end
        if (out_load) begin
            m_tdata_reg <= out_data;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ESA_ASSERT_IMPL(a_write_in_range, mem_we, in_range)
    `ESA_ASSERT_IMPL(a_done_in_div, div_res.done, state_reg == ST_DIV)
    `ESA_ASSERT_IMPL(a_rem_below_div, state_reg == ST_UPDATE, div_res.remainder < divisor)
    `ESA_ASSERT_NEXT(a_poll_fetch,
        accept && (s_tuser == OP_POLL) && s_in_range && s_tdata[VALID_BIT],
        state_reg == ST_FETCH)

endmodule

### src/esa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module esa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/esa_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on esa_pkg.
module esa_div
    import esa_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CPS_W-1:0] divisor,
    output div_res_t         res
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0]     quo_reg;
    logic [CPS_W-1:0]     part_reg;
    logic [CPS_W-1:0]     dsr_reg;

    logic [CPS_W:0]   trial;
    logic [CPS_W:0]   diff;
    logic             fits;
    logic [CPS_W-1:0] part_next;

    // partial remainder stays below twice the divisor, so diff fits CPS_W bits
    always_comb begin
        trial     = {part_reg, quo_reg[SUM_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        fits      = (trial >= {1'b0, dsr_reg});
        part_next = fits ? diff[CPS_W-1:0] : trial[CPS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(SUM_W - 1);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end else begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg  <= dividend;
            part_reg <= '0;
            dsr_reg  <= divisor;
        end else if (busy_reg) begin
            quo_reg  <= {quo_reg[SUM_W-2:0], fits};
            part_reg <= part_next;
        end
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = part_reg;

endmodule

### tb/tb_encoder_step_accumulator_top.sv
// Self-checking testbench for encoder_step_accumulator_top: directed and random polls/reads.
// Predicts every read result from its own copy of the encoder table; depends on esa_pkg.
module tb_encoder_step_accumulator_top;
    import esa_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int SETTLE_CYCLES  = 40;      // wait_idle margin, longer than a poll holds the block
    localparam int CYCLE_LIMIT    = 2000000; // several times the slowest clean run
    localparam int RANDOM_PER_CPS = 225;     // counted items per random phase
    localparam int REPORT_MAX     = 10;

    localparam int SAT_HI = int'($signed(STEP_ACC_MAX));
    localparam int SAT_LO = int'($signed(STEP_ACC_MIN));

    // receiver stall styles, re-picked every stretch of cycles
    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_PATTERN,
        RDY_SPARSE
    } stall_mode_t;

    // ------------------------------------------------------------------
    // DUT connections; every input is known from time zero
    // ------------------------------------------------------------------
    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_wen   = 1'b0;
    logic [CPS_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;   // [7:0] index, [23:8] raw, [24] valid
    logic                s_tuser   = OP_POLL;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [CNT_W-1:0]    m_tdata;

    encoder_step_accumulator_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shadow encoder table and the step count predictor
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] shadow_prev [NUM_ENCODERS];
    int               shadow_rem  [NUM_ENCODERS];
    int               shadow_acc  [NUM_ENCODERS];
    logic [CPS_W-1:0] shadow_cps = CPS_RESET;

    logic [CNT_W-1:0] expected_deltas [$];

    int mismatches  = 0;
    int cycle_count = 0;
    int burst_left  = 0;

    initial begin
        for (int i = 0; i < NUM_ENCODERS; i++) begin
            shadow_prev[i] = '0;
            shadow_rem[i]  = 0;
            shadow_acc[i]  = 0;
        end
    end

    // Applies one accepted transaction to the shadow table; a read queues its result.
    function automatic void predict_detents(input logic op, input logic [IN_IDX_W-1:0] idx,
                                            input logic [CNT_W-1:0] raw, input logic ok);
        logic signed [CNT_W-1:0] wrapped;
        int divisor;
        int sum;
        int quot;
        int total;
        if (op == OP_READ) begin
            if (idx < NUM_ENCODERS) begin
                expected_deltas.push_back(CNT_W'(shadow_acc[idx]));
                shadow_acc[idx] = 0;
            end else begin
                expected_deltas.push_back('0);
            end
        end else if (idx < NUM_ENCODERS && ok) begin
            divisor = (shadow_cps == 0) ? 1 : int'(shadow_cps);
            wrapped = raw - shadow_prev[idx];          // 16-bit wrapped difference
            sum     = shadow_rem[idx] + int'(wrapped);
            quot    = sum / divisor;                   // truncates toward zero
            total   = shadow_acc[idx] + quot;
            shadow_prev[idx] = raw;
            shadow_rem[idx]  = sum % divisor;          // sign follows the sum
            shadow_acc[idx]  = (total > SAT_HI) ? SAT_HI : (total < SAT_LO) ? SAT_LO : total;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every m_* transaction against the oldest prediction
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] want;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_deltas.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result transaction: step count=%0d",
                             $signed(m_tdata));
            end else begin
                want = expected_deltas.pop_front();
                if (m_tdata !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("step count mismatch: expected %0d, got %0d",
                                 $signed(want), $signed(m_tdata));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure: its own stall pattern, independent of the sender
    // ------------------------------------------------------------------
    stall_mode_t rdy_mode    = RDY_ALWAYS;
    int          rdy_left    = 0;
    logic [7:0]  rdy_pattern = 8'hFF;

    always @(posedge aclk) begin
        if (rdy_left == 0) begin
            rdy_mode    = stall_mode_t'($urandom_range(0, 3));
            rdy_left    = $urandom_range(20, 120);
            rdy_pattern = 8'($urandom);
        end else begin
            rdy_left--;
        end
        case (rdy_mode)
            RDY_ALWAYS:  m_tready <= 1'b1;
            RDY_COIN:    m_tready <= 1'($urandom_range(0, 1));
            RDY_PATTERN: begin
                m_tready    <= rdy_pattern[0];
                rdy_pattern = {rdy_pattern[0], rdy_pattern[7:1]};
            end
            default:     m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // One input transaction. tvalid stays high across a burst; when the burst
    // ends it drops for a random gap. Callers that need to wait call
    // wait_idle in the same time step, which lowers tvalid.
    task automatic send_item(input logic op, input logic [IN_IDX_W-1:0] idx,
                             input logic [CNT_W-1:0] raw, input logic ok);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'b0, ok, raw, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_detents(op, idx, raw, ok);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            // mostly short gaps, now and then long enough to land after a poll finishes
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 4))
                @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // Block must be idle: no result outstanding and any poll finished.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_deltas.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cps(input logic [CPS_W-1:0] value);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        shadow_cps = value;
        cfg_wen   <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Cleared table: in-range reads give zero, bad indices give zero too.
    task automatic test_reset_reads();
        send_item(OP_READ, 8'd0, '0, 1'b1);
        send_item(OP_READ, 8'(NUM_ENCODERS - 1), '0, 1'b1);
        send_item(OP_READ, 8'(NUM_ENCODERS), 16'hFFFF, 1'b0);
        send_item(OP_READ, 8'hFF, 16'hFFFF, 1'b1);
    endtask

    // Default divisor of 2: positive and negative steps with leftover remainder.
    task automatic test_basic_steps();
        send_item(OP_POLL, 8'd0, 16'd5, 1'b1);
        send_item(OP_POLL, 8'd0, 16'd6, 1'b1);
        send_item(OP_POLL, 8'd1, 16'hFFFD, 1'b1);
        send_item(OP_READ, 8'd0, '0, 1'b0);
        send_item(OP_READ, 8'd1, '0, 1'b0);
    endtask

    // Invalid sample and bad-index poll leave the table alone.
    task automatic test_ignored_polls();
        send_item(OP_POLL, 8'd0, 16'd1000, 1'b0);
        send_item(OP_POLL, 8'hFF, 16'd1000, 1'b1);
        send_item(OP_READ, 8'd0, '0, 1'b1);
    endtask

    // Counter crossing from 0x7FFF to 0x8001 counts as +2.
    task automatic test_counter_wrap();
        send_item(OP_POLL, 8'd2, 16'h7FFF, 1'b1);
        send_item(OP_POLL, 8'd2, 16'h8001, 1'b1);
        send_item(OP_READ, 8'd2, '0, 1'b1);
    endtask

    // Divisor 1, full-scale jumps: accumulator pins at both rails.
    task automatic test_saturation();
        wait_idle();
        write_cps(8'd1);
        send_item(OP_POLL, 8'd3, 16'h7FFF, 1'b1);
        send_item(OP_POLL, 8'd3, 16'hFFFE, 1'b1);
        send_item(OP_READ, 8'd3, '0, 1'b1);
        send_item(OP_POLL, 8'd3, 16'h7FFF, 1'b1);
        send_item(OP_POLL, 8'd3, 16'hFFFF, 1'b1);   // delta -32768
        send_item(OP_POLL, 8'd3, 16'h7FFF, 1'b1);
        send_item(OP_READ, 8'd3, '0, 1'b1);
    endtask

    // Divisor 0 acts as 1.
    task automatic test_zero_divisor();
        wait_idle();
        write_cps(8'd0);
        send_item(OP_POLL, 8'd0, 16'd7, 1'b1);
        send_item(OP_READ, 8'd0, '0, 1'b1);
    endtask

    // Largest divisor: remainder runs near its 9-bit limits.
    task automatic test_max_divisor();
        wait_idle();
        write_cps(8'hFF);
        send_item(OP_POLL, 8'd1, 16'd1000, 1'b1);
        send_item(OP_POLL, 8'd1, 16'hFC18, 1'b1);   // -1000
        send_item(OP_READ, 8'd1, '0, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------

    // Next sample for an encoder: mostly a few steps away, sometimes a jump.
    function automatic logic [CNT_W-1:0] next_sample(input int idx);
        int span;
        int delta;
        span = (shadow_cps == 0) ? 4 : 4 * int'(shadow_cps);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: delta = $urandom_range(0, span);
            6, 7:             delta = $urandom_range(0, 32767);
            8:                return CNT_W'($urandom);
            default:          delta = 0;
        endcase
        if ($urandom_range(0, 1)) delta = -delta;
        return shadow_prev[idx] + CNT_W'(delta);
    endfunction

    // Mostly well-formed polls and reads on live encoders, some noise.
    task automatic test_random_phase(input logic [CPS_W-1:0] cps, input int count);
        int done;
        int pick;
        int idx;
        wait_idle();
        write_cps(cps);
        done = 0;
        while (done < count) begin
            pick = $urandom_range(0, 99);
            idx  = $urandom_range(0, NUM_ENCODERS - 1);
            if (pick < 65) begin
                send_item(OP_POLL, 8'(idx), next_sample(idx), 1'b1);
                done++;
            end else if (pick < 85) begin
                send_item(OP_READ, 8'(idx), 16'($urandom), 1'($urandom));
                done++;
            end else if (pick < 90) begin
                send_item(OP_READ, 8'($urandom_range(NUM_ENCODERS, 255)), 16'($urandom),
                          1'($urandom));
                done++;
            end else if (pick < 95) begin
                // ignored: sample flagged invalid
                send_item(OP_POLL, 8'(idx), 16'($urandom), 1'b0);
            end else begin
                // ignored: encoder index out of range
                send_item(OP_POLL, 8'($urandom_range(NUM_ENCODERS, 255)), 16'($urandom),
                          1'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_reads();
        test_basic_steps();
        test_ignored_polls();
        test_counter_wrap();
        test_saturation();
        test_zero_divisor();
        test_max_divisor();

        test_random_phase(CPS_RESET, RANDOM_PER_CPS);
        test_random_phase(8'd1, RANDOM_PER_CPS);
        test_random_phase(8'hFF, RANDOM_PER_CPS);
        test_random_phase(8'd0, RANDOM_PER_CPS);
        test_random_phase(8'($urandom_range(3, 254)), RANDOM_PER_CPS);
        test_random_phase(8'($urandom_range(3, 16)), RANDOM_PER_CPS);

        wait_idle();
        if (mismatches == 0 && expected_deltas.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/esa_pkg.sv
src/esa_ram.sv
src/esa_div.sv
src/encoder_step_accumulator_top.sv
tb/tb_encoder_step_accumulator_top.sv
